FILE: rtl/core/tiva_pkg.sv
// ----------------------------------------------------------------------------
// tiva_pkg
// Shared constants and types of the track identity vote accumulator.
// ----------------------------------------------------------------------------
package tiva_pkg;

	localparam int TRACK_SLOTS = 16;
	localparam int IDENTITIES  = 20;
	localparam int CANDIDATES  = 3;

	localparam int SLOT_W     = $clog2(TRACK_SLOTS);
	localparam int ID_W       = 5;
	localparam int CONF_W     = 7;
	localparam int TAG_W      = 64;
	localparam int SCORE_W    = 24;
	localparam int FRAME_W    = 16;
	localparam int THR_W      = 20;
	localparam int WIN_W      = 10;
	localparam int VOTE_DEPTH = TRACK_SLOTS * IDENTITIES;
	localparam int VADDR_W    = $clog2(VOTE_DEPTH);
	localparam int ICNT_W     = $clog2(IDENTITIES + 1);
	localparam int KCNT_W     = $clog2(CANDIDATES + 1);

	localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};
	localparam logic [FRAME_W-1:0] FRAME_MAX = {FRAME_W{1'b1}};

	localparam logic [1:0] ST_UNDET   = 2'd0;
	localparam logic [1:0] ST_UNKNOWN = 2'd1;
	localparam logic [1:0] ST_KNOWN   = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	localparam logic [7:0] REG_THRESHOLD = 8'd0;
	localparam logic [7:0] REG_WINDOW    = 8'd1;

	typedef struct packed {
		logic                                table_full;
		logic                                fresh;
		logic [SLOT_W-1:0]                   slot;
		logic [KCNT_W-1:0]                   faces;
		logic [CANDIDATES-1:0][ID_W-1:0]     ids;
		logic [CANDIDATES-1:0][CONF_W-1:0]   confs;
	} cmd_t;

endpackage

FILE: rtl/core/tiva_front.sv
// ----------------------------------------------------------------------------
// tiva_front
// Track tag lookup and slot allocation; issues one command per transaction with a nonzero track id.
// ----------------------------------------------------------------------------
module tiva_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   accept,
	input  logic [tiva_pkg::TAG_W-1:0]             track_id,
	input  logic [1:0]                             face_count,
	input  logic [tiva_pkg::CANDIDATES-1:0][4:0]   ids,
	input  logic [tiva_pkg::CANDIDATES-1:0][6:0]   confs,
	output logic                                   push,
	output tiva_pkg::cmd_t                         cmd
);
	import tiva_pkg::*;

	logic [TAG_W-1:0]       tag_q [TRACK_SLOTS];
	logic [TRACK_SLOTS-1:0] valid_q;
	logic                   hit;
	logic                   has_free;
	logic [SLOT_W-1:0]      hit_slot;
	logic [SLOT_W-1:0]      free_slot;
	logic [KCNT_W-1:0]      faces;

	always_comb begin
		hit       = 1'b0;
		has_free  = 1'b0;
		hit_slot  = '0;
		free_slot = '0;
		for (int s = TRACK_SLOTS - 1; s >= 0; s--) begin
			if (valid_q[s]) begin
				if (tag_q[s] == track_id) begin
					hit      = 1'b1;
					hit_slot = SLOT_W'(s);
				end
			end else begin
				has_free  = 1'b1;
				free_slot = SLOT_W'(s);
			end
		end
		if (KCNT_W'(face_count) > KCNT_W'(CANDIDATES))
			faces = KCNT_W'(CANDIDATES);
		else
			faces = KCNT_W'(face_count);
	end

	assign push           = accept && (track_id != '0);
	assign cmd.table_full = !hit && !has_free;
	assign cmd.fresh      = !hit;
	assign cmd.slot       = hit ? hit_slot : free_slot;
	assign cmd.faces      = faces;
	assign cmd.ids        = ids;
	assign cmd.confs      = confs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (push && !hit && has_free) begin
			valid_q[free_slot] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !hit && has_free)
			tag_q[free_slot] <= track_id;
	end

endmodule

FILE: rtl/core/tiva_fifo.sv
// ----------------------------------------------------------------------------
// tiva_fifo
// Two-entry command queue between lookup and histogram update.
// ----------------------------------------------------------------------------
module tiva_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tiva_pkg::cmd_t wdata,
	input  logic           pop,
	output tiva_pkg::cmd_t rdata,
	output logic           empty,
	output logic           full
);
	import tiva_pkg::*;

	cmd_t       mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= !wp_q;
			if (pop)
				rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wdata;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) full |-> !push)
		else $error("Command queue overflow.");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) empty |-> !pop)
		else $error("Command queue underflow.");

endmodule

FILE: rtl/core/tiva_back.sv
// ----------------------------------------------------------------------------
// tiva_back
// Per-track vote histogram update, argmax sweep and determination rule.
// ----------------------------------------------------------------------------
module tiva_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_empty,
	input  tiva_pkg::cmd_t                   q_head,
	output logic                             q_pop,
	input  logic [tiva_pkg::THR_W-1:0]       thr,
	input  logic [tiva_pkg::WIN_W-1:0]       win,
	output logic                             idle,
	output logic                             res_valid,
	output logic [tiva_pkg::ID_W-1:0]        res_id,
	output logic [tiva_pkg::SCORE_W-1:0]     res_score,
	output logic [1:0]                       res_status
);
	import tiva_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DISP = 4'd1;
	localparam logic [3:0] S_CLR  = 4'd2;
	localparam logic [3:0] S_AFT  = 4'd3;
	localparam logic [3:0] S_VRD  = 4'd4;
	localparam logic [3:0] S_VWR  = 4'd5;
	localparam logic [3:0] S_ARG  = 4'd6;
	localparam logic [3:0] S_RULE = 4'd7;
	localparam logic [3:0] S_DIV  = 4'd8;
	localparam logic [3:0] S_MUL  = 4'd9;
	localparam logic [3:0] S_CMP  = 4'd10;
	localparam logic [3:0] S_DONE = 4'd11;

	logic [3:0]               st_q;
	cmd_t                     cmd_q;
	logic [KCNT_W-1:0]        k_q;
	logic [ICNT_W-1:0]        cnt_q;
	logic [VADDR_W-1:0]       base_q;
	logic [FRAME_W-1:0]       fc_q;
	logic                     det_q;
	logic                     kn_q;
	logic [ID_W-1:0]          bid_q;
	logic [SCORE_W-1:0]       bsc_q;
	logic [WIN_W-1:0]         win_q;
	logic [FRAME_W-1:0]       dvd_q;
	logic [FRAME_W-1:0]       quo_q;
	logic [WIN_W:0]           rem_q;
	logic [THR_W+FRAME_W-1:0] need_q;

	logic [FRAME_W-1:0] fc_mem  [TRACK_SLOTS];
	logic               det_mem [TRACK_SLOTS];
	logic               kn_mem  [TRACK_SLOTS];
	logic [ID_W-1:0]    bid_mem [TRACK_SLOTS];
	logic [SCORE_W-1:0] bsc_mem [TRACK_SLOTS];
	logic [SCORE_W-1:0] vmem    [VOTE_DEPTH];
	logic [SCORE_W-1:0] vm_rdata_q;

	logic [VADDR_W-1:0] vm_raddr;
	logic [VADDR_W-1:0] vm_waddr;
	logic [SCORE_W-1:0] vm_wdata;
	logic               vm_we;
	logic [ID_W-1:0]    cur_id;
	logic [CONF_W-1:0]  cur_conf;
	logic [SCORE_W:0]   vsum;
	logic [WIN_W-1:0]   win_eff;
	logic [WIN_W:0]     rem_sh;
	logic [WIN_W:0]     rem_sub;

	assign idle     = (st_q == S_IDLE);
	assign q_pop    = idle && !q_empty;
	assign cur_id   = cmd_q.ids[k_q];
	assign cur_conf = cmd_q.confs[k_q];
	assign vsum     = {1'b0, vm_rdata_q} + (SCORE_W+1)'(cur_conf);
	assign win_eff  = (win == '0) ? WIN_W'(1) : win;
	assign rem_sh   = {rem_q[WIN_W-1:0], dvd_q[FRAME_W-1]};
	assign rem_sub  = rem_sh - {1'b0, win_q};

	always_comb begin
		vm_raddr = base_q;
		vm_we    = 1'b0;
		vm_waddr = base_q + VADDR_W'(cnt_q);
		vm_wdata = '0;
		case (st_q)
			S_VRD: vm_raddr = base_q + VADDR_W'(cur_id);
			S_ARG: begin
				if (cnt_q < ICNT_W'(IDENTITIES))
					vm_raddr = base_q + VADDR_W'(cnt_q);
			end
			S_CLR: vm_we = 1'b1;
			S_VWR: begin
				vm_we    = 1'b1;
				vm_waddr = base_q + VADDR_W'(cur_id);
				vm_wdata = vsum[SCORE_W] ? SCORE_MAX : vsum[SCORE_W-1:0];
			end
			default: vm_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		vm_rdata_q <= vmem[vm_raddr];
		if (vm_we)
			vmem[vm_waddr] <= vm_wdata;
	end

	always_ff @(posedge clk) begin
		if (st_q == S_DONE) begin
			fc_mem[cmd_q.slot]  <= fc_q;
			det_mem[cmd_q.slot] <= det_q;
			kn_mem[cmd_q.slot]  <= kn_q;
			bid_mem[cmd_q.slot] <= bid_q;
			bsc_mem[cmd_q.slot] <= bsc_q;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: cmd_q <= q_head;
			S_DISP: begin
				base_q <= VADDR_W'(cmd_q.slot) * VADDR_W'(IDENTITIES);
				cnt_q  <= '0;
				if (cmd_q.fresh) begin
					fc_q  <= '0;
					det_q <= 1'b0;
					kn_q  <= 1'b0;
					bid_q <= '0;
					bsc_q <= '0;
				end else begin
					fc_q  <= fc_mem[cmd_q.slot];
					det_q <= det_mem[cmd_q.slot];
					kn_q  <= kn_mem[cmd_q.slot];
					bid_q <= bid_mem[cmd_q.slot];
					bsc_q <= bsc_mem[cmd_q.slot];
				end
			end
			S_CLR: cnt_q <= cnt_q + 1'b1;
			S_AFT: begin
				k_q <= '0;
				if (cmd_q.faces != '0 && fc_q != FRAME_MAX)
					fc_q <= fc_q + 1'b1;
			end
			S_VRD: begin
				if (k_q >= cmd_q.faces) begin
					cnt_q <= '0;
					bid_q <= '0;
					bsc_q <= '0;
				end else if (cur_id >= ID_W'(IDENTITIES)) begin
					k_q <= k_q + 1'b1;
				end
			end
			S_VWR: k_q <= k_q + 1'b1;
			S_ARG: begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q != '0 && vm_rdata_q >= bsc_q) begin
					bsc_q <= vm_rdata_q;
					bid_q <= ID_W'(cnt_q - 1'b1);
				end
			end
			S_RULE: begin
				win_q <= win_eff;
				dvd_q <= fc_q;
				quo_q <= '0;
				rem_q <= '0;
				cnt_q <= '0;
				if (fc_q < FRAME_W'(win_eff)) begin
					det_q <= (bsc_q >= SCORE_W'(thr));
					kn_q  <= (bsc_q >= SCORE_W'(thr));
				end else begin
					det_q <= 1'b1;
				end
			end
			S_DIV: begin
				cnt_q <= cnt_q + 1'b1;
				dvd_q <= {dvd_q[FRAME_W-2:0], 1'b0};
				if (rem_sh >= {1'b0, win_q}) begin
					rem_q <= rem_sub;
					quo_q <= {quo_q[FRAME_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[FRAME_W-2:0], 1'b0};
				end
			end
			S_MUL: need_q <= (THR_W+FRAME_W)'(thr) * (THR_W+FRAME_W)'(quo_q);
			S_CMP: begin
				if (rem_q == '0 && !kn_q && (THR_W+FRAME_W)'(bsc_q) > need_q)
					kn_q <= 1'b1;
			end
			default: cnt_q <= cnt_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_IDLE;
			res_valid  <= 1'b0;
			res_id     <= '0;
			res_score  <= '0;
			res_status <= ST_UNDET;
		end else begin
			res_valid <= 1'b0;
			case (st_q)
				S_IDLE: if (!q_empty) st_q <= S_DISP;
				S_DISP: begin
					if (cmd_q.table_full) begin
						res_valid  <= 1'b1;
						res_id     <= '0;
						res_score  <= '0;
						res_status <= ST_FULL;
						st_q       <= S_IDLE;
					end else if (cmd_q.fresh) begin
						st_q <= S_CLR;
					end else begin
						st_q <= S_AFT;
					end
				end
				S_CLR: if (cnt_q == ICNT_W'(IDENTITIES - 1)) st_q <= S_AFT;
				S_AFT: begin
					if (cmd_q.faces != '0)
						st_q <= S_VRD;
					else if (cmd_q.fresh)
						st_q <= S_DONE;
					else
						st_q <= S_RULE;
				end
				S_VRD: begin
					if (k_q >= cmd_q.faces)
						st_q <= S_ARG;
					else if (cur_id < ID_W'(IDENTITIES))
						st_q <= S_VWR;
				end
				S_VWR: st_q <= S_VRD;
				S_ARG: if (cnt_q == ICNT_W'(IDENTITIES)) st_q <= S_RULE;
				S_RULE: begin
					if (fc_q < FRAME_W'(win_eff))
						st_q <= S_DONE;
					else
						st_q <= S_DIV;
				end
				S_DIV: if (cnt_q == ICNT_W'(FRAME_W - 1)) st_q <= S_MUL;
				S_MUL: st_q <= S_CMP;
				S_CMP: st_q <= S_DONE;
				S_DONE: begin
					res_valid <= 1'b1;
					res_id    <= bid_q;
					res_score <= bsc_q;
					if (kn_q && det_q)
						res_status <= ST_KNOWN;
					else if (det_q)
						res_status <= ST_UNKNOWN;
					else
						res_status <= ST_UNDET;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status == ST_FULL |-> res_score == '0 && res_id == '0)
		else $error("Table full result carries a nonzero payload.");
	a_result_ends_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> idle)
		else $error("Result issued while a command is still in progress.");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> st_q == S_DISP)
		else $error("Popped command was not dispatched.");

endmodule

FILE: rtl/core/track_identity_vote_accumulator_top.sv
// ----------------------------------------------------------------------------
// track_identity_vote_accumulator_top
// Detection to track identity vote accumulator with configuration registers.
// ----------------------------------------------------------------------------
// Channel   Handshake                 Payload
// input     start / busy              track_id, face_count, cand_id_k, cand_conf_k
// config    cfg_valid / cfg_ready     cfg_index, cfg_data
// result    result_valid strobe       best_id, best_score, status
//
// A new track first clears its 20 entry vote row. Each valid vote is read from
// and written back to the vote memory; after the votes an argmax sweep runs
// over the row, and once the frame count reaches the window a restoring
// divider splits the frame count by the window for the known check.
// Busy stays high until the strobe cycle. Configuration is taken only while idle.
// Reset clears slot valid bits and control state. Results cannot be stalled.
// ----------------------------------------------------------------------------
module track_identity_vote_accumulator_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [63:0]                         track_id,
	input  logic [1:0]                          face_count,
	input  logic [4:0]                          cand_id_0,
	input  logic [6:0]                          cand_conf_0,
	input  logic [4:0]                          cand_id_1,
	input  logic [6:0]                          cand_conf_1,
	input  logic [4:0]                          cand_id_2,
	input  logic [6:0]                          cand_conf_2,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [7:0]                          cfg_index,
	input  logic [19:0]                         cfg_data,
	output logic                                result_valid,
	output logic [4:0]                          best_id,
	output logic [23:0]                         best_score,
	output logic [1:0]                          status
);
	import tiva_pkg::*;

	logic [THR_W-1:0]                  thr_q;
	logic [WIN_W-1:0]                  win_q;
	logic                              push;
	logic                              pop;
	logic                              q_empty;
	logic                              q_full;
	logic                              back_idle;
	cmd_t                              cmd_in;
	cmd_t                              cmd_out;
	logic [CANDIDATES-1:0][ID_W-1:0]   ids;
	logic [CANDIDATES-1:0][CONF_W-1:0] confs;

	assign ids       = {cand_id_2, cand_id_1, cand_id_0};
	assign confs     = {cand_conf_2, cand_conf_1, cand_conf_0};
	assign busy      = !q_empty || !back_idle;
	assign cfg_ready = !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_W'(2000);
			win_q <= WIN_W'(10);
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_THRESHOLD)
				thr_q <= cfg_data;
			else if (cfg_index == REG_WINDOW)
				win_q <= cfg_data[WIN_W-1:0];
		end
	end

	tiva_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (start && !busy),
		.track_id   (track_id),
		.face_count (face_count),
		.ids        (ids),
		.confs      (confs),
		.push       (push),
		.cmd        (cmd_in)
	);

	tiva_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cmd_in),
		.pop    (pop),
		.rdata  (cmd_out),
		.empty  (q_empty),
		.full   (q_full)
	);

	tiva_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_head     (cmd_out),
		.q_pop      (pop),
		.thr        (thr_q),
		.win        (win_q),
		.idle       (back_idle),
		.res_valid  (result_valid),
		.res_id     (best_id),
		.res_score  (best_score),
		.res_status (status)
	);

	a_busy_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && track_id != '0 |=> busy)
		else $error("Accepted transaction did not raise busy.");
	a_queue_single: assert property (@(posedge clk) disable iff (!arst_n) !q_full)
		else $error("More than one command outstanding.");
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !pop)
		else $error("Command popped in the result cycle.");

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the track identity vote accumulator. Detections
// go to a class that keeps its own track table, vote histograms and
// determination flags. Each result strobe is compared against the oldest
// predicted result. Registers are rewritten between phases of random traffic.
// ----------------------------------------------------------------------------
module tb;
	import tiva_pkg::*;

	typedef struct {
		logic [ID_W-1:0]    id;
		logic [SCORE_W-1:0] score;
		logic [1:0]         st;
	} vote_result_t;

	class vote_scoreboard;
		logic [TAG_W-1:0] tag [TRACK_SLOTS];
		bit               used [TRACK_SLOTS];
		int unsigned      frames [TRACK_SLOTS];
		bit               det [TRACK_SLOTS];
		bit               known [TRACK_SLOTS];
		int unsigned      last_id [TRACK_SLOTS];
		int unsigned      last_score [TRACK_SLOTS];
		int unsigned      votes [TRACK_SLOTS][IDENTITIES];
		int unsigned      threshold;
		int unsigned      window;
		vote_result_t     pending [$];
		int               errors;

		function new();
			threshold = 2000;
			window = 10;
			errors = 0;
			for (int s = 0; s < TRACK_SLOTS; s++) begin
				used[s] = 0;
				clear_track(s);
			end
		endfunction

		function void clear_track(int s);
			frames[s] = 0;
			det[s] = 0;
			known[s] = 0;
			last_id[s] = 0;
			last_score[s] = 0;
			for (int i = 0; i < IDENTITIES; i++) votes[s][i] = 0;
		endfunction

		function void queue_expected(vote_result_t r);
			pending = {pending, r};
		endfunction

		function void write_reg(logic [7:0] index, logic [THR_W-1:0] data);
			if (index == REG_THRESHOLD) threshold = data;
			else if (index == REG_WINDOW) window = data[WIN_W-1:0];
		endfunction

		function void decide(int s);
			int unsigned w;
			longint unsigned need;
			w = (window == 0) ? 1 : window;
			if (frames[s] < w) begin
				det[s] = (last_score[s] >= threshold);
				known[s] = det[s];
			end else begin
				det[s] = 1;
				if (frames[s] % w == 0 && !known[s]) begin
					need = longint'(threshold) * longint'(frames[s] / w);
					if (longint'(last_score[s]) > need) known[s] = 1;
				end
			end
		endfunction

		function void note_detection(logic [TAG_W-1:0] tid, logic [1:0] fc,
				logic [ID_W-1:0] ids [CANDIDATES], logic [CONF_W-1:0] confs [CANDIDATES]);
			int slot, free_slot, n;
			bit fresh;
			int unsigned best, bid, v;
			vote_result_t r;
			if (tid == 0) return;
			slot = -1;
			free_slot = -1;
			fresh = 0;
			n = (fc > CANDIDATES) ? CANDIDATES : fc;
			for (int s = 0; s < TRACK_SLOTS; s++) begin
				if (used[s]) begin
					if (tag[s] == tid && slot < 0) slot = s;
				end else if (free_slot < 0) begin
					free_slot = s;
				end
			end
			if (slot < 0) begin
				if (free_slot < 0) begin
					r = '{id: 0, score: 0, st: ST_FULL};
					queue_expected(r);
					return;
				end
				slot = free_slot;
				used[slot] = 1;
				tag[slot] = tid;
				clear_track(slot);
				fresh = 1;
			end
			if (n > 0) begin
				if (frames[slot] < FRAME_MAX) frames[slot]++;
				for (int k = 0; k < n; k++) begin
					if (ids[k] < IDENTITIES) begin
						v = votes[slot][ids[k]] + confs[k];
						votes[slot][ids[k]] = (v > SCORE_MAX) ? SCORE_MAX : v;
					end
				end
				best = 0;
				bid = 0;
				for (int i = 0; i < IDENTITIES; i++) begin
					if (votes[slot][i] >= best) begin
						best = votes[slot][i];
						bid = i;
					end
				end
				last_id[slot] = bid;
				last_score[slot] = best;
				decide(slot);
			end else if (fresh) begin
				r = '{id: 0, score: 0, st: ST_UNDET};
				queue_expected(r);
				return;
			end else begin
				decide(slot);
			end
			r.id = last_id[slot];
			r.score = last_score[slot];
			if (known[slot] && det[slot]) r.st = ST_KNOWN;
			else if (det[slot]) r.st = ST_UNKNOWN;
			else r.st = ST_UNDET;
			queue_expected(r);
		endfunction

		function void check_result(logic [ID_W-1:0] id, logic [SCORE_W-1:0] score,
				logic [1:0] st);
			vote_result_t e;
			if (pending.size() == 0) begin
				$error("result with no transaction outstanding: id %0d score %0d status %0d",
					id, score, st);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (id !== e.id) begin
				$error("best_id expected %0d actual %0d", e.id, id);
				errors++;
			end
			if (score !== e.score) begin
				$error("best_score expected %0d actual %0d", e.score, score);
				errors++;
			end
			if (st !== e.st) begin
				$error("status expected %0d actual %0d", e.st, st);
				errors++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [TAG_W-1:0]    track_id;
	logic [1:0]          face_count;
	logic [ID_W-1:0]     cand_id_0, cand_id_1, cand_id_2;
	logic [CONF_W-1:0]   cand_conf_0, cand_conf_1, cand_conf_2;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [7:0]          cfg_index;
	logic [19:0]         cfg_data;
	logic                result_valid;
	logic [ID_W-1:0]     best_id;
	logic [SCORE_W-1:0]  best_score;
	logic [1:0]          status;

	vote_scoreboard   sb;
	logic [TAG_W-1:0] track_pool [15];
	int               sent;

	track_identity_vote_accumulator_top u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.track_id(track_id), .face_count(face_count),
		.cand_id_0(cand_id_0), .cand_conf_0(cand_conf_0),
		.cand_id_1(cand_id_1), .cand_conf_1(cand_conf_1),
		.cand_id_2(cand_id_2), .cand_conf_2(cand_conf_2),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.result_valid(result_valid), .best_id(best_id),
		.best_score(best_score), .status(status)
	);

	initial clk = 0;
	always #4 clk = ~clk;

	initial begin
		#20_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid) sb.check_result(best_id, best_score, status);
	end

	task automatic send_detection(logic [TAG_W-1:0] tid, logic [1:0] fc,
			logic [ID_W-1:0] ids [CANDIDATES], logic [CONF_W-1:0] confs [CANDIDATES],
			bit may_idle);
		int gap;
		if (may_idle && $urandom_range(0, 99) < 8) begin
			start = 0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(negedge clk);
		end
		start = 1;
		track_id = tid;
		face_count = fc;
		cand_id_0 = ids[0];
		cand_id_1 = ids[1];
		cand_id_2 = ids[2];
		cand_conf_0 = confs[0];
		cand_conf_1 = confs[1];
		cand_conf_2 = confs[2];
		do @(posedge clk); while (busy);
		sb.note_detection(tid, fc, ids, confs);
		sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		start = 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (120) @(negedge clk);
	endtask

	task automatic write_reg(logic [7:0] index, logic [19:0] data);
		cfg_valid = 1;
		cfg_index = index;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(index, data);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic random_detection(bit may_idle);
		logic [TAG_W-1:0]  tid;
		logic [1:0]        fc;
		logic [ID_W-1:0]   ids [CANDIDATES];
		logic [CONF_W-1:0] confs [CANDIDATES];
		int                pick;
		pick = $urandom_range(0, 99);
		if (pick < 3) tid = 0;
		else if (pick < 6) tid = {$urandom, $urandom};
		else tid = track_pool[$urandom_range(0, 14)];
		fc = ($urandom_range(0, 99) < 20) ? 2'd0 : 2'($urandom_range(1, 3));
		for (int k = 0; k < CANDIDATES; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) ids[k] = 5'($urandom_range(IDENTITIES, 31));
			else if (pick < 70) ids[k] = 5'($urandom_range(0, 3));
			else ids[k] = 5'($urandom_range(0, IDENTITIES - 1));
			pick = $urandom_range(0, 99);
			if (pick < 8) confs[k] = 7'($urandom_range(101, 127));
			else if (pick < 12) confs[k] = 7'(pick[0] ? 100 : 0);
			else confs[k] = 7'($urandom_range(0, 100));
		end
		send_detection(tid, fc, ids, confs, may_idle);
	endtask

	initial begin
		logic [ID_W-1:0]   ids [CANDIDATES];
		logic [CONF_W-1:0] confs [CANDIDATES];
		logic [19:0]       thr_set [7];
		logic [9:0]        win_set [7];
		sb = new();
		sent = 0;
		start = 0;
		track_id = 0;
		face_count = 0;
		cand_id_0 = 0;
		cand_id_1 = 0;
		cand_id_2 = 0;
		cand_conf_0 = 0;
		cand_conf_1 = 0;
		cand_conf_2 = 0;
		cfg_valid = 0;
		cfg_index = 0;
		cfg_data = 0;
		arst_n = 0;
		track_pool[0] = 64'hFFFF_FFFF_FFFF_FFFF;
		track_pool[1] = 64'd1;
		for (int i = 2; i < 15; i++) track_pool[i] = {$urandom, $urandom} | 64'd1;
		repeat (4) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		ids = '{5'd0, 5'd0, 5'd0};
		confs = '{7'd0, 7'd0, 7'd0};
		send_detection(64'd0, 2'd3, ids, confs, 0);
		send_detection(track_pool[0], 2'd0, ids, confs, 0);
		send_detection(track_pool[0], 2'd0, ids, confs, 0);
		ids = '{5'd31, 5'd25, 5'd20};
		send_detection(track_pool[0], 2'd3, ids, confs, 0);
		ids = '{5'd19, 5'd0, 5'd31};
		confs = '{7'd127, 7'd100, 7'd127};
		send_detection(track_pool[1], 2'd3, ids, confs, 0);
		ids = '{5'd0, 5'd19, 5'd7};
		confs = '{7'd100, 7'd100, 7'd0};
		send_detection(track_pool[1], 2'd2, ids, confs, 0);
		send_detection(track_pool[1], 2'd0, ids, confs, 0);
		ids = '{5'd5, 5'd5, 5'd5};
		confs = '{7'd127, 7'd127, 7'd127};
		for (int i = 0; i < 8; i++) send_detection(track_pool[2], 2'd3, ids, confs, 0);
		send_detection(track_pool[2], 2'd1, ids, confs, 0);
		send_detection(track_pool[2], 2'd0, ids, confs, 0);
		wait_drained();

		thr_set = '{20'd2000, 20'd0, 20'hFFFFF, 20'd300, 20'd0, 20'd500, 20'd1000000};
		win_set = '{10'd10, 10'd1, 10'd1023, 10'd3, 10'd0, 10'd2, 10'd7};
		for (int p = 0; p < 7; p++) begin
			if (p > 0) begin
				wait_drained();
				if (p == 6) begin
					thr_set[p] = 20'($urandom_range(0, 4000));
					win_set[p] = 10'($urandom_range(1, 1023));
				end
				write_reg(REG_THRESHOLD, thr_set[p]);
				write_reg(REG_WINDOW, win_set[p]);
			end
			for (int n = 0; n < 255; n++) begin
				if (p == 3 && n == 100) wait_drained();
				random_detection(!(p == 2 || (p == 3 && n < 100)));
			end
		end
		start = 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
